// File: rtl/lei_pkg.sv
package lei_pkg;

  localparam int unsigned MAX_STEPS_DEF = 63;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned UPC_W = 5;
  localparam int unsigned CNT_W = 6;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SIGMA = 3'd0;
  localparam logic [2:0] CFG_RHO   = 3'd1;
  localparam logic [2:0] CFG_BETA  = 3'd2;
  localparam logic [2:0] CFG_DT    = 3'd3;
  localparam logic [2:0] CFG_STEPS = 3'd4;

  localparam logic [30:0] SIGMA_RST = 31'd655360;
  localparam logic [30:0] RHO_RST   = 31'd1835008;
  localparam logic [30:0] BETA_RST  = 31'd174763;
  localparam logic [16:0] DT_RST    = 17'd655;
  localparam logic [5:0]  STEPS_RST = 6'd8;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_T3,
    SRC_SIGMA,
    SRC_RHO,
    SRC_BETA,
    SRC_DT
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_X,
    DST_Y,
    DST_Z,
    DST_T0,
    DST_T1,
    DST_T2,
    DST_T3
  } dst_e;

  typedef enum logic {
    BR_NEXT,
    BR_TEST
  } br_e;

  typedef struct packed {
    op_e              op;
    src_e             src_a;
    src_e             src_b;
    dst_e             dst;
    logic             emit;
    logic             inc;
    br_e              br;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  // First micro-op of the Euler step loop.
  localparam logic [UPC_W-1:0] LOOP_PC = 5'd3;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic ctrl_t uop(input op_e op, input src_e a, input src_e b,
                                input dst_e d, input logic emit, input logic inc,
                                input br_e br, input logic [UPC_W-1:0] tgt);
    ctrl_t c;
    c.op     = op;
    c.src_a  = a;
    c.src_b  = b;
    c.dst    = d;
    c.emit   = emit;
    c.inc    = inc;
    c.br     = br;
    c.target = tgt;
    return c;
  endfunction

  // Microprogram: perturb the start point, then one Euler step per loop pass.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:  c = uop(OP_ADD, SRC_X,     SRC_T0, DST_X,  1'b0, 1'b0, BR_NEXT, '0);
      5'd1:  c = uop(OP_ADD, SRC_Y,     SRC_T1, DST_Y,  1'b0, 1'b0, BR_NEXT, '0);
      5'd2:  c = uop(OP_ADD, SRC_Z,     SRC_T2, DST_Z,  1'b1, 1'b0, BR_TEST, LOOP_PC);
      5'd3:  c = uop(OP_SUB, SRC_Y,     SRC_X,  DST_T0, 1'b0, 1'b0, BR_NEXT, '0);
      5'd4:  c = uop(OP_MUL, SRC_SIGMA, SRC_T0, DST_T0, 1'b0, 1'b0, BR_NEXT, '0);
      5'd5:  c = uop(OP_SUB, SRC_RHO,   SRC_Z,  DST_T1, 1'b0, 1'b0, BR_NEXT, '0);
      5'd6:  c = uop(OP_MUL, SRC_T1,    SRC_X,  DST_T1, 1'b0, 1'b0, BR_NEXT, '0);
      5'd7:  c = uop(OP_SUB, SRC_T1,    SRC_Y,  DST_T1, 1'b0, 1'b0, BR_NEXT, '0);
      5'd8:  c = uop(OP_MUL, SRC_X,     SRC_Y,  DST_T2, 1'b0, 1'b0, BR_NEXT, '0);
      5'd9:  c = uop(OP_MUL, SRC_BETA,  SRC_Z,  DST_T3, 1'b0, 1'b0, BR_NEXT, '0);
      5'd10: c = uop(OP_SUB, SRC_T2,    SRC_T3, DST_T2, 1'b0, 1'b0, BR_NEXT, '0);
      5'd11: c = uop(OP_MUL, SRC_T0,    SRC_DT, DST_T0, 1'b0, 1'b0, BR_NEXT, '0);
      5'd12: c = uop(OP_ADD, SRC_X,     SRC_T0, DST_X,  1'b0, 1'b0, BR_NEXT, '0);
      5'd13: c = uop(OP_MUL, SRC_T1,    SRC_DT, DST_T1, 1'b0, 1'b0, BR_NEXT, '0);
      5'd14: c = uop(OP_ADD, SRC_Y,     SRC_T1, DST_Y,  1'b0, 1'b0, BR_NEXT, '0);
      5'd15: c = uop(OP_MUL, SRC_T2,    SRC_DT, DST_T2, 1'b0, 1'b0, BR_NEXT, '0);
      5'd16: c = uop(OP_ADD, SRC_Z,     SRC_T2, DST_Z,  1'b1, 1'b1, BR_TEST, LOOP_PC);
      default: c = uop(OP_ADD, SRC_X,   SRC_X,  DST_NONE, 1'b0, 1'b0, BR_TEST, '0);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/lorenz_euler_integrator_core.sv
// Lorenz-63 forward Euler integrator, signed Q16.16 with saturating arithmetic.
// Command channel: an item (start point and perturbation) is taken on a rising
// edge with start_i high and busy_o low. busy_o stays high until the run ends.
// Result channel: each trajectory point is marked on the point ports for exactly one
// cycle by result_valid_o. The receiver cannot stall it, so there is
// no back-pressure and no result is ever held.
// Configuration: cfg_valid_i/cfg_ready_o write transaction carrying a register
// index and data; cfg_ready_o is always high. Write only while idle.
// Sequencing: the perturbation micro-ops put point 0 on the point ports, and each
// pass of the Euler step loop puts the next point there. An item keeps the block
// busy until its last step is done, and the next item can be taken at the edge
// after busy_o falls. The sequence comes from the microprogram: one micro-op per
// cycle on a single shared arithmetic unit.
// Reset: registers return to sigma 10, rho 28, beta 8/3, dt 0.01, 8 steps;
// the sequencer goes idle and no result is strobed.
module lorenz_euler_integrator_core #(
  parameter int unsigned MAX_STEPS = lei_pkg::MAX_STEPS_DEF,
  parameter int unsigned FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] noise_x_i,
  input  logic signed [31:0] noise_y_i,
  input  logic signed [31:0] noise_z_i,
  output logic               result_valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic [5:0]         point_index_o,
  output logic               last_point_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam logic [lei_pkg::CNT_W-1:0] MAX_N = lei_pkg::CNT_W'(MAX_STEPS);

  logic [30:0] sigma_q, rho_q, beta_q;
  logic [16:0] dt_q;
  logic [5:0]  steps_q;

  logic                        busy_q;
  logic [lei_pkg::UPC_W-1:0]   pc_q;
  logic [lei_pkg::CNT_W-1:0]   cnt_q, cnt_d, n_q, n_d;
  logic                        valid_q;

  logic signed [31:0] x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q;
  logic signed [31:0] opa, opb, alu_res;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [5:0]         idx_q;
  logic               last_q;

  lei_pkg::ctrl_t ctrl;
  logic           accept;
  logic           run_end;

  assign accept = start_i && !busy_q;
  assign ctrl   = lei_pkg::ucode(pc_q);
  assign cnt_d  = cnt_q + lei_pkg::CNT_W'(ctrl.inc);
  assign n_d    = (steps_q > MAX_N) ? MAX_N : steps_q;
  assign run_end = (ctrl.br == lei_pkg::BR_TEST) && (cnt_d == n_q);

  function automatic logic signed [31:0] pick(input lei_pkg::src_e s,
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z, input logic signed [31:0] t0,
      input logic signed [31:0] t1, input logic signed [31:0] t2,
      input logic signed [31:0] t3, input logic [30:0] sg, input logic [30:0] rh,
      input logic [30:0] bt, input logic [16:0] dt);
    logic signed [31:0] r;
    case (s)
      lei_pkg::SRC_X:     r = x;
      lei_pkg::SRC_Y:     r = y;
      lei_pkg::SRC_Z:     r = z;
      lei_pkg::SRC_T0:    r = t0;
      lei_pkg::SRC_T1:    r = t1;
      lei_pkg::SRC_T2:    r = t2;
      lei_pkg::SRC_T3:    r = t3;
      lei_pkg::SRC_SIGMA: r = $signed({1'b0, sg});
      lei_pkg::SRC_RHO:   r = $signed({1'b0, rh});
      lei_pkg::SRC_BETA:  r = $signed({1'b0, bt});
      lei_pkg::SRC_DT:    r = $signed({15'd0, dt});
      default:            r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(ctrl.src_a, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
               sigma_q, rho_q, beta_q, dt_q);
    opb = pick(ctrl.src_b, x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q,
               sigma_q, rho_q, beta_q, dt_q);
  end

  lei_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .op_i (ctrl.op),
    .a_i  (opa),
    .b_i  (opb),
    .res_o(alu_res)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= lei_pkg::SIGMA_RST;
      rho_q   <= lei_pkg::RHO_RST;
      beta_q  <= lei_pkg::BETA_RST;
      dt_q    <= lei_pkg::DT_RST;
      steps_q <= lei_pkg::STEPS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lei_pkg::CFG_SIGMA: sigma_q <= cfg_data_i[30:0];
        lei_pkg::CFG_RHO:   rho_q   <= cfg_data_i[30:0];
        lei_pkg::CFG_BETA:  beta_q  <= cfg_data_i[30:0];
        lei_pkg::CFG_DT:    dt_q    <= cfg_data_i[16:0];
        lei_pkg::CFG_STEPS: steps_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer: program counter, step counter and run length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= busy_q && ctrl.emit;
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
        cnt_q  <= '0;
        n_q    <= n_d;
      end else if (busy_q) begin
        cnt_q <= cnt_d;
        if (ctrl.br == lei_pkg::BR_NEXT) begin
          pc_q <= pc_q + 1'b1;
        end else if (run_end) begin
          busy_q <= 1'b0;
        end else begin
          pc_q <= ctrl.target;
        end
      end
    end
  end

  // Working registers and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q  <= start_x_i;
      y_q  <= start_y_i;
      z_q  <= start_z_i;
      t0_q <= noise_x_i;
      t1_q <= noise_y_i;
      t2_q <= noise_z_i;
    end else if (busy_q) begin
      case (ctrl.dst)
        lei_pkg::DST_X:  x_q  <= alu_res;
        lei_pkg::DST_Y:  y_q  <= alu_res;
        lei_pkg::DST_Z:  z_q  <= alu_res;
        lei_pkg::DST_T0: t0_q <= alu_res;
        lei_pkg::DST_T1: t1_q <= alu_res;
        lei_pkg::DST_T2: t2_q <= alu_res;
        lei_pkg::DST_T3: t3_q <= alu_res;
        default: ;
      endcase
    end
    // The emitting micro-op writes z, so the new z is taken from the unit.
    if (busy_q && ctrl.emit) begin
      px_q   <= x_q;
      py_q   <= y_q;
      pz_q   <= alu_res;
      idx_q  <= cnt_d;
      last_q <= run_end;
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign point_z_o      = pz_q;
  assign point_index_o  = idx_q;
  assign last_point_o   = last_q;

endmodule

// File: rtl/lei_alu.sv
module lei_alu #(
  parameter int unsigned FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
  input  lei_pkg::op_e        op_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [31:0]  res_o
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] a_w;
  logic signed [63:0] b_w;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;

  always_comb begin
    a_w  = 64'(a_i);
    b_w  = 64'(b_i);
    prod = a_w * b_w;
    // Round half up: add half an LSB, then an arithmetic (floor) shift.
    rnd  = (prod + HALF) >>> FRAC_BITS;
    case (op_i)
      lei_pkg::OP_ADD: res_o = lei_pkg::sat32(a_w + b_w);
      lei_pkg::OP_SUB: res_o = lei_pkg::sat32(a_w - b_w);
      lei_pkg::OP_MUL: res_o = lei_pkg::sat32(rnd);
      default:         res_o = '0;
    endcase
  end

endmodule

// File: dv/lorenz_euler_integrator_core_tb.sv
`timescale 1ns / 100ps

module lorenz_euler_integrator_core_tb;

  localparam int unsigned MAX_STEPS   = 63;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          DRAIN_GUARD = 5000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 30;

  typedef logic signed [63:0] wide_t;

  localparam wide_t S32_HI     = 64'sd2147483647;
  localparam wide_t S32_LO     = -64'sd2147483648;
  localparam wide_t ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
  } item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [5:0]         idx;
    logic               last;
  } point_t;

  class trajectory_scoreboard;
    logic [30:0]  sigma_q;
    logic [30:0]  rho_q;
    logic [30:0]  beta_q;
    logic [16:0]  dt_q;
    logic [5:0]   steps_q;
    wide_t        cur_x;
    wide_t        cur_y;
    wide_t        cur_z;
    int unsigned  last_run;
    point_t       expected_points[$];
    int           commands;
    int           points_seen;
    int           faults;

    function new();
      sigma_q     = 31'd655360;
      rho_q       = 31'd1835008;
      beta_q      = 31'd174763;
      dt_q        = 17'd655;
      steps_q     = 6'd8;
      cur_x       = '0;
      cur_y       = '0;
      cur_z       = '0;
      last_run    = 0;
      commands    = 0;
      points_seen = 0;
      faults      = 0;
    endfunction

    function wide_t clamp32(wide_t v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
    endfunction

    function wide_t qadd(wide_t a, wide_t b);
      return clamp32(a + b);
    endfunction

    function wide_t qsub(wide_t a, wide_t b);
      return clamp32(a - b);
    endfunction

    // Round half up, then an arithmetic shift, which floors negative values.
    function wide_t qmul(wide_t a, wide_t b);
      wide_t p;
      p = a * b + ROUND_HALF;
      return clamp32(p >>> FRAC_BITS);
    endfunction

    function void write_reg(logic [2:0] index, logic [31:0] data);
      case (index)
        lei_pkg::CFG_SIGMA: sigma_q = data[30:0];
        lei_pkg::CFG_RHO:   rho_q   = data[30:0];
        lei_pkg::CFG_BETA:  beta_q  = data[30:0];
        lei_pkg::CFG_DT:    dt_q    = data[16:0];
        lei_pkg::CFG_STEPS: steps_q = data[5:0];
        default: ;
      endcase
    endfunction

    function void expect_point(wide_t px, wide_t py, wide_t pz, int unsigned k, bit fin);
      point_t pt;
      pt.x    = px[31:0];
      pt.y    = py[31:0];
      pt.z    = pz[31:0];
      pt.idx  = k[5:0];
      pt.last = fin;
      expected_points.push_back(pt);
    endfunction

    function void note_command(item_t it);
      wide_t       px;
      wide_t       py;
      wide_t       pz;
      wide_t       d0;
      wide_t       d1;
      wide_t       d2;
      int unsigned n;
      n  = (steps_q > MAX_STEPS) ? MAX_STEPS : steps_q;
      px = qadd($signed(it.sx), $signed(it.nx));
      py = qadd($signed(it.sy), $signed(it.ny));
      pz = qadd($signed(it.sz), $signed(it.nz));
      expect_point(px, py, pz, 0, n == 0);
      for (int unsigned i = 1; i <= n; i++) begin
        d0 = qmul(sigma_q, qsub(py, px));
        d1 = qsub(qmul(qsub(rho_q, pz), px), py);
        d2 = qsub(qmul(px, py), qmul(beta_q, pz));
        px = qadd(px, qmul(d0, dt_q));
        py = qadd(py, qmul(d1, dt_q));
        pz = qadd(pz, qmul(d2, dt_q));
        expect_point(px, py, pz, i, i == n);
      end
      cur_x    = px;
      cur_y    = py;
      cur_z    = pz;
      last_run = n;
      commands++;
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected point (%0d, %0d, %0d) index %0d last %b",
                   got.x, got.y, got.z, got.idx, got.last);
        end
        return;
      end
      want = expected_points.pop_front();
      points_seen++;
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.idx !== want.idx || got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("point mismatch: expected (%0d, %0d, %0d) index %0d last %b",
                   want.x, want.y, want.z, want.idx, want.last);
          $display("                got      (%0d, %0d, %0d) index %0d last %b",
                   got.x, got.y, got.z, got.idx, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cmd_start = 1'b0;
  logic        cmd_busy;
  item_t       cmd       = '0;
  logic        res_valid;
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [31:0] res_z;
  logic [5:0]  res_idx;
  logic        res_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  trajectory_scoreboard sb;
  point_t seen_point;
  int     cycles   = 0;
  int     settings = 0;

  lorenz_euler_integrator_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (cmd_start),
    .busy_o         (cmd_busy),
    .start_x_i      (cmd.sx),
    .start_y_i      (cmd.sy),
    .start_z_i      (cmd.sz),
    .noise_x_i      (cmd.nx),
    .noise_y_i      (cmd.ny),
    .noise_z_i      (cmd.nz),
    .result_valid_o (res_valid),
    .point_x_o      (res_x),
    .point_y_o      (res_y),
    .point_z_o      (res_z),
    .point_index_o  (res_idx),
    .last_point_o   (res_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycles);
      $display("lorenz_euler_integrator_core_tb: FAIL");
      $finish;
    end
  end

  // Every transaction is seen here at the edge that completes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (cmd_start && !cmd_busy) begin
        sb.note_command(cmd);
      end
      if (res_valid) begin
        seen_point.x    = res_x;
        seen_point.y    = res_y;
        seen_point.z    = res_z;
        seen_point.idx  = res_idx;
        seen_point.last = res_last;
        sb.check_point(seen_point);
      end
    end
  end

  function automatic item_t mk_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic [31:0] e, logic [31:0] f);
    item_t it;
    it.sx = a;
    it.sy = b;
    it.sz = c;
    it.nx = d;
    it.ny = e;
    it.nz = f;
    return it;
  endfunction

  // Mostly points near the attractor, with some raw words and extremes.
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom();
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = int'($urandom_range(0, 80 << 16)) - (40 << 16);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_noise();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom();
      1: v = '0;
      default: v = int'($urandom_range(0, 1 << 13)) - (1 << 12);
    endcase
    return v;
  endfunction

  function automatic item_t rand_item();
    return mk_item(rand_coord(), rand_coord(), rand_coord(),
                   rand_noise(), rand_noise(), rand_noise());
  endfunction

  function automatic logic [31:0] rand_reg(logic [31:0] typical_max, logic [31:0] top);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = top;
      2, 3: v = $urandom();
      default: v = $urandom_range(0, typical_max);
    endcase
    return v;
  endfunction

  // Holds start high until the block takes the command.
  task automatic send_cmd(input item_t it);
    cmd       <= it;
    cmd_start <= 1'b1;
    do @(posedge clk); while (cmd_busy);
  endtask

  // The data lines carry junk while start is low; the block must ignore it.
  task automatic pause_cmd(input int n);
    cmd       <= mk_item($urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
    cmd_start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [31:0] sigma, input logic [31:0] rho,
                            input logic [31:0] beta, input logic [31:0] dt,
                            input logic [31:0] steps);
    cfg_write(lei_pkg::CFG_SIGMA, sigma);
    cfg_write(lei_pkg::CFG_RHO, rho);
    cfg_write(lei_pkg::CFG_BETA, beta);
    cfg_write(lei_pkg::CFG_DT, dt);
    cfg_write(lei_pkg::CFG_STEPS, steps);
    cfg_valid <= 1'b0;
    settings++;
    @(posedge clk);
  endtask

  // The first edge lets the last accepted command reach the scoreboard.
  task automatic wait_idle();
    int guard;
    guard = 0;
    cmd_start <= 1'b0;
    @(posedge clk);
    while ((sb.pending() != 0 || cmd_busy) && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [31:0] steps;
    bit          idling;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Values after reset: sigma 10, rho 28, beta 8/3, dt 0.01, eight steps.
    send_cmd(mk_item('0, '0, '0, '0, '0, '0));
    send_cmd(mk_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0));
    send_cmd(mk_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_cmd(mk_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_cmd(mk_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_cmd(mk_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    wait_idle();

    // Writes to unused indexes must change nothing; then zero steps, where
    // the perturbed start alone is emitted and marked as the last point.
    for (int i = int'(lei_pkg::CFG_STEPS) + 1; i < 8; i++) begin
      cfg_write(3'(i), $urandom());
    end
    set_config(32'd655360, 32'd1835008, 32'd174763, 32'd655, 32'hFFFF_FFC0);
    send_cmd(rand_item());
    send_cmd(rand_item());
    wait_idle();

    // Every gain at its top, dt of exactly one and the longest run.
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'd63);
    send_cmd(rand_item());
    send_cmd(rand_item());
    wait_idle();

    set_config('0, '0, '0, '0, 32'd5);
    send_cmd(rand_item());
    send_cmd(rand_item());
    wait_idle();

    // A time step above one: dt keeps the low 17 bits of the word, just under two.
    set_config(32'd655360, 32'd1835008, 32'd174763, 32'hFFFF_FFFF, 32'd4);
    send_cmd(rand_item());
    send_cmd(rand_item());
    wait_idle();

    set_config(32'd655360, 32'd1835008, 32'd174763, 32'd655, 32'd20);
    send_cmd(mk_item(32'h0001_0000, 32'h0002_0000, 32'h0014_0000, '0, '0, 32'h0000_0100));
    pause_cmd(3);
    send_cmd(mk_item(32'hFFF8_0000, 32'hFFF6_0000, 32'h0019_0000, '0, '0, '0));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        steps = 32'd63;
      end else if (ph == 7) begin
        steps = '0;
      end else begin
        steps = $urandom_range(1, 12);
      end
      set_config(rand_reg(20 << 16, 32'h7FFF_FFFF), rand_reg(50 << 16, 32'h7FFF_FFFF),
                 rand_reg(5 << 16, 32'h7FFF_FFFF), rand_reg(1500, 32'h0001_0000), steps);
      idling = (ph < PHASES - 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_cmd(rand_item());
        if (idling && $urandom_range(0, 2) == 0) begin
          pause_cmd($urandom_range(1, 11));
        end
        if (idling && $urandom_range(0, 47) == 0) begin
          wait_idle();
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected points never arrived", sb.pending());
      sb.faults++;
    end
    $display("Sent %0d commands under %0d register settings; %0d points compared.",
             sb.commands, settings, sb.points_seen);
    $display("Runs of 0 to 63 steps, gains and time step at both ends, saturated inputs.");
    if (sb.faults == 0) begin
      $display("lorenz_euler_integrator_core_tb: PASS");
    end else begin
      $display("%0d failures", sb.faults);
      $display("lorenz_euler_integrator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
